@@ rtl/core/lrfq_pkg.sv @@
// Shared types and constants for the first-quadrant line rasterizer.
// No dependencies; every rtl/core module imports this package.
`default_nettype none
package lrfq_pkg;

   // Field width of every coordinate on the ports
   localparam int PIXEL_BITS  = 6;
   // Coordinates are masked to this many bits before use (2..PIXEL_BITS)
   localparam int COORD_BITS  = 6;
   // Error term: 2*COORD_BITS range plus sign
   localparam int ERR_BITS    = COORD_BITS + 2;
   // Command queue between setup and stepper
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [PIXEL_BITS-1:0] start_x;
      logic [PIXEL_BITS-1:0] start_y;
      logic [PIXEL_BITS-1:0] end_x;
      logic [PIXEL_BITS-1:0] end_y;
   } req_type;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] pixel_x;
      logic [PIXEL_BITS-1:0] pixel_y;
      logic                  last_pixel;
      logic                  bad_order;
   } rsp_type;

   // One classified line command, ready for the stepper
   typedef struct packed {
      logic                       bad;
      logic                       steep;
      logic [COORD_BITS-1:0]      x0;
      logic [COORD_BITS-1:0]      y0;
      logic [COORD_BITS-1:0]      steps;
      logic signed [ERR_BITS-1:0] err_init;
      logic signed [ERR_BITS-1:0] inc_step;  // added when the minor axis moves
      logic signed [ERR_BITS-1:0] inc_hold;  // added when it holds
   } setup_type;

endpackage
`default_nettype wire

@@ rtl/core/lrfq_front.sv @@
// Line setup: masks the endpoints, checks their order and derives the
// major axis, step count and error increments. Depends on lrfq_pkg.
`default_nettype none
module lrfq_front
   import lrfq_pkg::*;
(
   input  var req_type   cmd,
   output var setup_type setup
);

   logic [COORD_BITS-1:0] x0, y0, x1, y1;
   logic [COORD_BITS-1:0] dx, dy, major, minor;
   logic                  steep;
   logic [COORD_BITS:0]   diff;

   always_comb begin
      x0    = cmd.start_x[COORD_BITS-1:0];
      y0    = cmd.start_y[COORD_BITS-1:0];
      x1    = cmd.end_x[COORD_BITS-1:0];
      y1    = cmd.end_y[COORD_BITS-1:0];
      dx    = x1 - x0;
      dy    = y1 - y0;
      steep = dy > dx;
      major = steep ? dy : dx;
      minor = steep ? dx : dy;
      diff  = {1'b0, minor} - {1'b0, major};

      setup.bad      = (x1 < x0) || (y1 < y0);
      setup.steep    = steep;
      setup.x0       = x0;
      setup.y0       = y0;
      setup.steps    = major;
      setup.err_init = $signed({1'b0, minor, 1'b0}) - $signed({2'b00, major});
      setup.inc_step = $signed({diff, 1'b0});
      setup.inc_hold = $signed({1'b0, minor, 1'b0});
   end

endmodule
`default_nettype wire

@@ rtl/core/lrfq_queue.sv @@
// Short command queue between line setup and the pixel stepper.
// Depends on lrfq_pkg for setup_type and the queue depth.
`default_nettype none
module lrfq_queue
   import lrfq_pkg::*;
(
   input  var logic      clock,
   input  var logic      reset,
   input  var logic      push,
   input  var setup_type push_data,
   output var logic      full,
   input  var logic      pop,
   output var logic      not_empty,
   output var setup_type pop_data
);

   setup_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   function automatic logic [QPTR_BITS-1:0] next_ptr(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full      = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = do_push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/lrfq_back.sv @@
// Pixel stepper: walks one line a pixel per beat from the queued setup,
// holding the current pixel as the output register. Depends on lrfq_pkg.
`default_nettype none
module lrfq_back
   import lrfq_pkg::*;
(
   input  var logic      clock,
   input  var logic      reset,
   input  var logic      cmd_valid,
   input  var setup_type cmd,
   output var logic      cmd_pop,
   output var logic      rsp_valid,
   input  var logic      rsp_stall,
   output var rsp_type   rsp_payload
);

   logic                       busy_ff, busy_in;
   logic                       bad_ff, bad_in;
   logic                       steep_ff, steep_in;
   logic [COORD_BITS-1:0]      x_ff, x_in;
   logic [COORD_BITS-1:0]      y_ff, y_in;
   logic [COORD_BITS-1:0]      cnt_ff, cnt_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic signed [ERR_BITS-1:0] inc_step_ff, inc_step_in;
   logic signed [ERR_BITS-1:0] inc_hold_ff, inc_hold_in;
   logic                       last, beat, move_minor;

   assign last       = (cnt_ff == '0);
   assign beat       = busy_ff && !rsp_stall;
   assign move_minor = (err_ff > 0);
   assign cmd_pop    = cmd_valid && (!busy_ff || (beat && last));

   assign rsp_valid              = busy_ff;
   assign rsp_payload.pixel_x    = PIXEL_BITS'(x_ff);
   assign rsp_payload.pixel_y    = PIXEL_BITS'(y_ff);
   assign rsp_payload.last_pixel = last;
   assign rsp_payload.bad_order  = bad_ff;

   always_comb begin
      busy_in     = busy_ff;
      bad_in      = bad_ff;
      steep_in    = steep_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      cnt_in      = cnt_ff;
      err_in      = err_ff;
      inc_step_in = inc_step_ff;
      inc_hold_in = inc_hold_ff;
      if (cmd_pop) begin
         // load the next line; a bad command is one beat at the origin
         busy_in     = 1'b1;
         bad_in      = cmd.bad;
         steep_in    = cmd.steep;
         x_in        = cmd.bad ? '0 : cmd.x0;
         y_in        = cmd.bad ? '0 : cmd.y0;
         cnt_in      = cmd.bad ? '0 : cmd.steps;
         err_in      = cmd.err_init;
         inc_step_in = cmd.inc_step;
         inc_hold_in = cmd.inc_hold;
      end else if (beat && last) begin
         busy_in = 1'b0;
      end else if (beat) begin
         // advance the major axis, the minor one when the error is positive
         cnt_in = cnt_ff - 1'b1;
         err_in = err_ff + (move_minor ? inc_step_ff : inc_hold_ff);
         if (steep_ff) begin
            y_in = y_ff + 1'b1;
            x_in = x_ff + COORD_BITS'(move_minor);
         end else begin
            x_in = x_ff + 1'b1;
            y_in = y_ff + COORD_BITS'(move_minor);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      bad_ff      <= bad_in;
      steep_ff    <= steep_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      cnt_ff      <= cnt_in;
      err_ff      <= err_in;
      inc_step_ff <= inc_step_in;
      inc_hold_ff <= inc_hold_in;
   end

   a_bad_is_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && bad_ff) |-> (last && x_ff == '0 && y_ff == '0))
      else $error("bad-order beat is not a single origin pixel");

   a_major_steps: assert property (@(posedge clock) disable iff (reset)
      (beat && !last) |=> (busy_ff &&
         ($past(steep_ff) ? (y_ff == $past(y_ff) + 1'b1)
                          : (x_ff == $past(x_ff) + 1'b1))))
      else $error("major axis did not advance by one");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !cmd_valid) |=> !busy_ff)
      else $error("stepper went busy with no queued command");

endmodule
`default_nettype wire

@@ rtl/core/line_rasterizer_first_quadrant.sv @@
// An accepted command is written into the command queue and, with the stepper idle,
// loaded into the stepper's pixel register. One pixel per cycle while the pixel side
// does not stall: max(dx,dy)+1 pixels per line (up to 64), one for a bad-order command;
// the stepper's single pixel register sets this rate. A two-entry command queue lets
// lines follow gaplessly. Reset (synchronous, active high) empties the queue and idles
// the stepper. Depends on lrfq_pkg, lrfq_front, lrfq_queue and lrfq_back.
`default_nettype none
module line_rasterizer_first_quadrant
   import lrfq_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   output var logic    req_stall,
   input  var req_type req_payload,
   output var logic    rsp_valid,
   input  var logic    rsp_stall,
   output var rsp_type rsp_payload
);

   setup_type setup;     // classified command from the front
   setup_type q_head;    // oldest queued command
   logic      q_full;
   logic      q_valid;
   logic      q_pop;

   // Front: mask endpoints, flag bad order, pick the major axis
   lrfq_front u_front (
      .cmd   (req_payload),
      .setup (setup)
   );

   // Stall the request side only when the queue is full
   assign req_stall = q_full;

   lrfq_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (setup),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_head)
   );

   // Back: step the line, one pixel per response beat
   lrfq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (q_valid),
      .cmd         (q_head),
      .cmd_pop     (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

@@ bench/line_pixel_checker.sv @@
// Pixel checker for the first-quadrant line rasterizer: predicts every pixel of each
// accepted line command and compares the result beats against them in order.
// Depends on lrfq_pkg for the beat types and the coordinate widths.
module line_pixel_checker
   import lrfq_pkg::*;
(
   input  var logic    clock,
   input  var logic    reset,
   input  var logic    req_valid,
   input  var logic    req_stall,
   input  var req_type req_payload,
   input  var logic    rsp_valid,
   input  var logic    rsp_stall,
   input  var rsp_type rsp_payload,
   output int          pixels_due,
   output int          mismatches
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [PIXEL_BITS-1:0] coord_type;

   rsp_type pending_pixels[$];

   // Walk the midpoint line and queue every pixel it should produce.
   function automatic void trace_line(input req_type cmd);
      int      mask, x0, y0, x1, y1, dx, dy, steps, err, x, y, i;
      bit      steep;
      rsp_type pix;
      mask = (1 << COORD_BITS) - 1;
      x0 = int'(cmd.start_x) & mask;
      y0 = int'(cmd.start_y) & mask;
      x1 = int'(cmd.end_x) & mask;
      y1 = int'(cmd.end_y) & mask;
      if (x1 < x0 || y1 < y0) begin
         pix.pixel_x    = '0;
         pix.pixel_y    = '0;
         pix.last_pixel = 1'b1;
         pix.bad_order  = 1'b1;
         pending_pixels.push_back(pix);
         return;
      end
      dx    = x1 - x0;
      dy    = y1 - y0;
      steep = dy > dx;
      steps = steep ? dy : dx;
      err   = steep ? 2 * dx - dy : 2 * dy - dx;
      x     = x0;
      y     = y0;
      for (i = 0; i <= steps; i++) begin
         pix.pixel_x    = coord_type'(x);
         pix.pixel_y    = coord_type'(y);
         pix.last_pixel = (i == steps);
         pix.bad_order  = 1'b0;
         pending_pixels.push_back(pix);
         // minor axis moves only on a positive decision term
         if (err > 0) begin
            if (steep) x++;
            else y++;
            err += steep ? 2 * (dx - dy) : 2 * (dy - dx);
         end else begin
            err += steep ? 2 * dx : 2 * dy;
         end
         if (steep) y++;
         else x++;
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         pending_pixels.delete();
      end else begin
         if (req_valid && !req_stall) trace_line(req_payload);
         if (rsp_valid && !rsp_stall) begin
            if (pending_pixels.size() == 0) begin
               $display("%0t: unexpected pixel beat x=%0d y=%0d last=%0b bad=%0b", $time,
                        rsp_payload.pixel_x, rsp_payload.pixel_y,
                        rsp_payload.last_pixel, rsp_payload.bad_order);
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_payload.pixel_x !== want.pixel_x ||
                   rsp_payload.pixel_y !== want.pixel_y ||
                   rsp_payload.last_pixel !== want.last_pixel ||
                   rsp_payload.bad_order !== want.bad_order) begin
                  $display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b bad=%0b,",
                            " got x=%0d y=%0d last=%0b bad=%0b"},
                           $time, want.pixel_x, want.pixel_y, want.last_pixel,
                           want.bad_order, rsp_payload.pixel_x, rsp_payload.pixel_y,
                           rsp_payload.last_pixel, rsp_payload.bad_order);
                  mismatches++;
               end
            end
         end
      end
      pixels_due <= pending_pixels.size();
   end

endmodule

@@ bench/tb_top.sv @@
// Top of the line rasterizer bench: drives line commands and pixel back-pressure
// through several idling phases and gives the verdict.
// Depends on lrfq_pkg, line_rasterizer_first_quadrant and line_pixel_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import lrfq_pkg::*;

   typedef logic [PIXEL_BITS-1:0] coord_type;

   // Traffic phases; the pressure phase stalls the pixel side for a long stretch
   typedef enum int {
      PH_RESET,
      PH_DIRECT,
      PH_FREE,
      PH_SEND_IDLE,
      PH_RECV_STALL,
      PH_BOTH_IDLE,
      PH_PRESSURE
   } phase_type;

   localparam int HOLD_CYCLES  = 300;     // pixel-side hold-off in the pressure phase
   localparam int TAIL_CYCLES  = 16;      // settle time once every pixel is in
   localparam int RUN_LIMIT_NS = 4000000; // generous stop for a hung run

   logic      clock       = 1'b0;
   logic      reset       = 1'b1;
   logic      req_valid   = 1'b0;
   req_type   req_payload = '0;
   logic      rsp_stall   = 1'b0;
   logic      req_stall;
   logic      rsp_valid;
   rsp_type   rsp_payload;
   int        pixels_due;
   int        mismatches;
   phase_type phase       = PH_RESET;

   always #4 clock = ~clock;

   line_rasterizer_first_quadrant dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   line_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .pixels_due (pixels_due),
      .mismatches (mismatches)
   );

   // Per-phase percent chance of lengthening the command side's idle gap before a command
   function automatic int gap_share(input phase_type ph);
      case (ph)
         PH_SEND_IDLE: return 79;
         PH_BOTH_IDLE: return 37;
         default:      return 0;
      endcase
   endfunction

   // Percent of cycles the pixel side stalls in each phase
   function automatic int stall_share(input phase_type ph);
      case (ph)
         PH_RECV_STALL: return 79;
         PH_BOTH_IDLE:  return 37;
         default:       return 0;
      endcase
   endfunction

   function automatic req_type make_line(input int sx, input int sy, input int ex,
                                         input int ey);
      req_type cmd;
      cmd.start_x = coord_type'(sx);
      cmd.start_y = coord_type'(sy);
      cmd.end_x   = coord_type'(ex);
      cmd.end_y   = coord_type'(ey);
      return cmd;
   endfunction

   // Mostly well-formed lines, some axis-aligned or diagonal, and a share of
   // commands whose end lies left of or below the start.
   function automatic req_type random_line();
      int pick, sx, sy, ex, ey, span;
      pick = $urandom_range(99);
      sx   = $urandom_range(63);
      sy   = $urandom_range(63);
      if (pick < 15) begin
         // broken order on one axis, anything on the other
         if ($urandom_range(1) == 1) begin
            sx = $urandom_range(63, 1);
            ex = $urandom_range(sx - 1, 0);
            ey = $urandom_range(63);
         end else begin
            sy = $urandom_range(63, 1);
            ey = $urandom_range(sy - 1, 0);
            ex = $urandom_range(63);
         end
      end else if (pick < 25) begin
         // horizontal, vertical or 45-degree
         span = $urandom_range(63 - ((sx > sy) ? sx : sy));
         case ($urandom_range(2))
            0:       begin ex = sx + span; ey = sy;        end
            1:       begin ex = sx;        ey = sy + span; end
            default: begin ex = sx + span; ey = sy + span; end
         endcase
      end else if (pick < 65) begin
         // short lines keep the run quick
         ex = sx + $urandom_range((63 - sx > 9) ? 9 : 63 - sx);
         ey = sy + $urandom_range((63 - sy > 9) ? 9 : 63 - sy);
      end else begin
         ex = $urandom_range(63, sx);
         ey = $urandom_range(63, sy);
      end
      return make_line(sx, sy, ex, ey);
   endfunction

   // Offer one command beat after a random idle gap; hold it until accepted.
   task automatic offer_line(input req_type cmd, input int gap_pct);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < gap_pct) gap++;
      if (gap > 0) begin
         req_valid   <= 1'b0;
         req_payload <= random_line();   // junk while idle
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= cmd;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted pixel has come out.
   task automatic wait_all_drawn();
      req_valid <= 1'b0;
      do @(posedge clock); while (pixels_due != 0);
   endtask

   task automatic run_phase(input phase_type ph, input int lines);
      phase <= ph;
      repeat (lines) offer_line(random_line(), gap_share(ph));
      wait_all_drawn();
   endtask

   // Pixel side: random stalls per phase, plus one long hold-off counted here
   // when the pressure phase starts.
   always @(posedge clock) begin
      phase_type seen_phase;
      int        hold_left;
      if (phase != seen_phase) begin
         seen_phase = phase;
         if (phase == PH_PRESSURE) hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_share(phase));
      end
   end

   initial begin
      req_type directed[$];
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // single points at both corners
      directed.push_back(make_line(0, 0, 0, 0));
      directed.push_back(make_line(63, 63, 63, 63));
      // longest horizontal, vertical and diagonal lines
      directed.push_back(make_line(0, 0, 63, 0));
      directed.push_back(make_line(0, 0, 0, 63));
      directed.push_back(make_line(0, 0, 63, 63));
      directed.push_back(make_line(0, 63, 63, 63));
      directed.push_back(make_line(63, 0, 63, 63));
      // shallow and steep across the full field
      directed.push_back(make_line(0, 5, 63, 20));
      directed.push_back(make_line(10, 0, 25, 63));
      // one off the diagonal on either side
      directed.push_back(make_line(3, 3, 10, 9));
      directed.push_back(make_line(3, 3, 9, 10));
      // decision term lands on zero
      directed.push_back(make_line(0, 0, 8, 4));
      directed.push_back(make_line(0, 0, 4, 8));
      // alternating bit patterns
      directed.push_back(make_line(21, 42, 42, 63));
      directed.push_back(make_line(42, 21, 63, 42));
      directed.push_back(make_line(62, 62, 63, 63));
      directed.push_back(make_line(5, 7, 6, 7));
      // bad order: x only, y only, both, and one edge of each
      directed.push_back(make_line(1, 0, 0, 0));
      directed.push_back(make_line(0, 1, 0, 0));
      directed.push_back(make_line(63, 63, 0, 0));
      directed.push_back(make_line(63, 0, 0, 63));
      directed.push_back(make_line(0, 63, 63, 0));

      phase <= PH_DIRECT;
      foreach (directed[i]) offer_line(directed[i], 0);
      wait_all_drawn();

      run_phase(PH_FREE, 22);
      run_phase(PH_SEND_IDLE, 22);
      run_phase(PH_RECV_STALL, 22);
      run_phase(PH_BOTH_IDLE, 22);
      // keep offering while the pixel side holds off, so the command queue fills
      run_phase(PH_PRESSURE, 10);
      run_phase(PH_FREE, 10);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

   initial begin
      #RUN_LIMIT_NS;
      $display("%0t: run limit reached with %0d pixels outstanding", $time, pixels_due);
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
